FILE: design/cedf_pkg.sv
// Shared types and constants for the confirmation envelope deframer.
// No dependencies; every design file imports this package.
package cedf_pkg;

    localparam int MAX_MSG_BYTES   = 16384;
    localparam int KEY_FIELD_BYTES = 68;

    localparam int POS_W  = $clog2(MAX_MSG_BYTES + 1);
    localparam int SKIP_W = 17;

    localparam logic [POS_W-1:0]  MAX_POS    = POS_W'(MAX_MSG_BYTES);
    localparam logic [SKIP_W-1:0] KEYS_SPAN  = SKIP_W'(2 * KEY_FIELD_BYTES + 1);

    localparam logic [7:0] CH_KEY      = 8'h4b;  // 'K'
    localparam logic [7:0] CH_NOKEY    = 8'h5f;  // '_'
    localparam logic [7:0] CH_CONF     = 8'h43;  // 'C'
    localparam logic [7:0] CH_ONE      = 8'h31;  // '1'
    localparam logic [7:0] CH_COMMA    = 8'h2c;  // ','
    localparam logic [7:0] LEN_LONG_LT = 8'h20;
    localparam logic [7:0] MARK_B0     = 8'h7b;
    localparam logic [7:0] MARK_B2     = 8'h02;
    localparam logic [15:0] MARK_HEAD  = {MARK_B0, 8'h00};

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADTAG   = 3'd1;
    localparam logic [2:0] ST_TRUNC    = 3'd2;
    localparam logic [2:0] ST_NOTCONF  = 3'd3;
    localparam logic [2:0] ST_BADMAYBE = 3'd4;
    localparam logic [2:0] ST_TOOLONG  = 3'd5;

    typedef enum logic [3:0] {
        PH_TAG, PH_KLEN0, PH_KLEN1, PH_KSKIP, PH_VER0, PH_VER1, PH_MTAG,
        PH_MAYBE, PH_E2E0, PH_E2E1, PH_KEYS, PH_KEM, PH_TAIL, PH_SEARCH, PH_IDLE
    } phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] payload_offset;
        logic [14:0] payload_length;
        logic [15:0] agent_rev;
        logic [15:0] e2e_rev;
        logic        has_e2e;
        logic        has_kem;
        logic        had_sender_key;
    } result_t;

endpackage

FILE: design/confirmation_envelope_deframer.sv
// A result item is registered twice: the input register feeds the parser, and the
// result register loads the parser's item when the last byte advances.
// Throughput: one byte per cycle; the parse state updates in a single pass, and
// only a held result stalls a last byte.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser
// to the header tag phase. Top level; depends on cedf_pkg, cedf_parser, cedf_out_reg.
module confirmation_envelope_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  msg_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [14:0] payload_offset,
    output logic [14:0] payload_length,
    output logic [15:0] agent_rev,
    output logic [15:0] e2e_rev,
    output logic        has_e2e,
    output logic        has_kem,
    output logic        had_sender_key
);
    import cedf_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       advance;
    logic       slot_free;
    result_t    parsed_item;
    result_t    held_result;

    // a non-last byte never needs the result slot
    assign advance  = in_valid_reg && (!last_reg || slot_free);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= msg_byte;
            last_reg <= last;
        end
    end

    cedf_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .byte_val (byte_reg),
        .last_val (last_reg),
        .result   (parsed_item)
    );

    cedf_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && last_reg),
        .result_in  (parsed_item),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (held_result)
    );

    assign status         = held_result.status;
    assign payload_offset = held_result.payload_offset;
    assign payload_length = held_result.payload_length;
    assign agent_rev      = held_result.agent_rev;
    assign e2e_rev        = held_result.e2e_rev;
    assign has_e2e        = held_result.has_e2e;
    assign has_kem        = held_result.has_kem;
    assign had_sender_key = held_result.had_sender_key;

endmodule

FILE: design/cedf_parser.sv
// Header parse state and per-byte next-state logic; builds the result item.
// Depends on cedf_pkg.
module cedf_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       byte_val,
    input  logic             last_val,
    output cedf_pkg::result_t result
);
    import cedf_pkg::*;

    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    phase_t            phase_reg, phase_next;
    logic [SKIP_W-1:0] skip_end_reg, skip_end_next;
    logic [7:0]        length_high_reg, length_high_next;
    logic [15:0]       version_reg, version_next;
    logic [15:0]       e2e_version_reg, e2e_version_next;
    logic [2:0]        error_reg, error_next;
    logic [POS_W-1:0]  start_offset_reg, start_offset_next;
    logic [15:0]       recent_reg, recent_next;
    logic [POS_W-1:0]  match_pos_reg, match_pos_next;
    logic              match_found_reg, match_found_next;
    logic [2:0]        flags_reg, flags_next;

    logic [POS_W-1:0]  pos_inc;
    logic [SKIP_W-1:0] pos_plus1;
    logic [15:0]       skip_len;
    logic [POS_W-1:0]  offset;
    logic [2:0]        status;
    logic [POS_W:0]    match_end;

    always_comb
    begin
        byte_position_next = byte_position_reg;
        phase_next         = phase_reg;
        skip_end_next      = skip_end_reg;
        length_high_next   = length_high_reg;
        version_next       = version_reg;
        e2e_version_next   = e2e_version_reg;
        error_next         = error_reg;
        start_offset_next  = start_offset_reg;
        recent_next        = recent_reg;
        match_pos_next     = match_pos_reg;
        match_found_next   = match_found_reg;
        flags_next         = flags_reg;

        pos_inc   = byte_position_reg + POS_W'(1);
        pos_plus1 = SKIP_W'(pos_inc);
        skip_len  = {length_high_reg, byte_val};

        if (error_reg == ST_TOOLONG || byte_position_reg >= MAX_POS)
        begin
            // stop counting; too long overrides any earlier error
            error_next = ST_TOOLONG;
            phase_next = PH_IDLE;
        end
        else
        begin
            byte_position_next = pos_inc;
            unique case (phase_reg)
                PH_TAG:
                begin
                    if (byte_val == CH_KEY)
                    begin
                        flags_next[2] = 1'b1;
                        phase_next    = PH_KLEN0;
                    end
                    else if (byte_val == CH_NOKEY)
                        phase_next = PH_VER0;
                    else
                    begin
                        error_next = ST_BADTAG;
                        phase_next = PH_IDLE;
                    end
                end
                PH_KLEN0:
                begin
                    if (byte_val < LEN_LONG_LT)
                    begin
                        length_high_next = byte_val;
                        phase_next       = PH_KLEN1;
                    end
                    else
                    begin
                        skip_end_next = pos_plus1 + SKIP_W'(byte_val);
                        phase_next    = PH_KSKIP;
                    end
                end
                PH_KLEN1:
                begin
                    skip_end_next = pos_plus1 + SKIP_W'(skip_len);
                    phase_next    = (skip_len == 16'd0) ? PH_VER0 : PH_KSKIP;
                end
                PH_KSKIP:
                begin
                    if (pos_plus1 >= skip_end_reg)
                        phase_next = PH_VER0;
                end
                PH_VER0:
                begin
                    version_next = {byte_val, 8'h00};
                    phase_next   = PH_VER1;
                end
                PH_VER1:
                begin
                    version_next = {version_reg[15:8], byte_val};
                    phase_next   = PH_MTAG;
                end
                PH_MTAG:
                begin
                    if (byte_val == CH_CONF)
                        phase_next = PH_MAYBE;
                    else
                    begin
                        error_next = ST_NOTCONF;
                        phase_next = PH_IDLE;
                    end
                end
                PH_MAYBE:
                begin
                    if (byte_val == CH_ONE)
                    begin
                        flags_next[0] = 1'b1;
                        phase_next    = PH_E2E0;
                    end
                    else if (byte_val == CH_COMMA)
                    begin
                        start_offset_next = pos_inc;
                        phase_next        = PH_TAIL;
                    end
                    else
                    begin
                        error_next = ST_BADMAYBE;
                        phase_next = PH_IDLE;
                    end
                end
                PH_E2E0:
                begin
                    e2e_version_next = {byte_val, 8'h00};
                    phase_next       = PH_E2E1;
                end
                PH_E2E1:
                begin
                    e2e_version_next  = {e2e_version_reg[15:8], byte_val};
                    skip_end_next     = SKIP_W'(byte_position_reg) + KEYS_SPAN;
                    start_offset_next = POS_W'(SKIP_W'(byte_position_reg) + KEYS_SPAN);
                    phase_next        = PH_KEYS;
                end
                PH_KEYS:
                begin
                    if (pos_plus1 >= skip_end_reg)
                        phase_next = PH_KEM;
                end
                PH_KEM:
                begin
                    start_offset_next = pos_inc;
                    if (byte_val == CH_ONE)
                    begin
                        flags_next[1] = 1'b1;
                        recent_next   = 16'h0000;
                        phase_next    = PH_SEARCH;
                    end
                    else
                        phase_next = PH_TAIL;
                end
                PH_SEARCH:
                begin
                    // latch only the first marker
                    if (!match_found_reg && byte_val == MARK_B2 && recent_reg == MARK_HEAD)
                    begin
                        match_found_next = 1'b1;
                        match_pos_next   = byte_position_reg - POS_W'(2);
                    end
                    recent_next = {recent_reg[7:0], byte_val};
                end
                PH_TAIL, PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // result from the state after this byte
        match_end = {1'b0, match_pos_next} + (POS_W+1)'(5);
        status    = error_next;
        offset    = '0;
        if (status == ST_OK)
        begin
            unique case (phase_next)
                PH_KEM, PH_TAIL:
                    offset = start_offset_next;
                PH_SEARCH:
                begin
                    offset = start_offset_next;
                    if (match_found_next && match_end <= {1'b0, byte_position_next})
                        offset = match_pos_next;
                end
                default:
                    status = ST_TRUNC;
            endcase
        end

        result = '0;
        result.status = status;
        if (status == ST_OK)
        begin
            result.payload_offset = 15'(offset);
            result.payload_length = 15'(byte_position_next - offset);
            result.agent_rev      = version_next;
            result.e2e_rev        = e2e_version_next;
            result.has_e2e        = flags_next[0];
            result.has_kem        = flags_next[1];
            result.had_sender_key = flags_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            phase_reg         <= PH_TAG;
            skip_end_reg      <= '0;
            length_high_reg   <= '0;
            version_reg       <= '0;
            e2e_version_reg   <= '0;
            error_reg         <= ST_OK;
            start_offset_reg  <= '0;
            recent_reg        <= '0;
            match_pos_reg     <= '0;
            match_found_reg   <= 1'b0;
            flags_reg         <= '0;
        end
        else if (advance)
        begin
            if (last_val)
            begin
                // message done: back to reset values
                byte_position_reg <= '0;
                phase_reg         <= PH_TAG;
                skip_end_reg      <= '0;
                length_high_reg   <= '0;
                version_reg       <= '0;
                e2e_version_reg   <= '0;
                error_reg         <= ST_OK;
                start_offset_reg  <= '0;
                recent_reg        <= '0;
                match_pos_reg     <= '0;
                match_found_reg   <= 1'b0;
                flags_reg         <= '0;
            end
            else
            begin
                byte_position_reg <= byte_position_next;
                phase_reg         <= phase_next;
                skip_end_reg      <= skip_end_next;
                length_high_reg   <= length_high_next;
                version_reg       <= version_next;
                e2e_version_reg   <= e2e_version_next;
                error_reg         <= error_next;
                start_offset_reg  <= start_offset_next;
                recent_reg        <= recent_next;
                match_pos_reg     <= match_pos_next;
                match_found_reg   <= match_found_next;
                flags_reg         <= flags_next;
            end
        end
    end

endmodule

FILE: design/cedf_out_reg.sv
// Result register with valid/ready toward the consumer.
// Depends on cedf_pkg.
module cedf_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cedf_pkg::result_t result_in,
    output logic              slot_free,
    output logic              out_valid,
    input  logic              out_ready,
    output cedf_pkg::result_t result_out
);
    import cedf_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

endmodule

FILE: design/cedf_checker.sv
// Port-level checks for the confirmation envelope deframer, bound to the top.
// Depends on cedf_pkg.
module cedf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [14:0] payload_offset,
    input logic [14:0] payload_length,
    input logic [15:0] agent_rev,
    input logic [15:0] e2e_rev,
    input logic        has_e2e,
    input logic        has_kem,
    input logic        had_sender_key
);
    import cedf_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(payload_offset) && $stable(payload_length))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> payload_offset == 15'd0
            && payload_length == 15'd0 && agent_rev == 16'd0
            && e2e_rev == 16'd0 && !has_e2e && !has_kem && !had_sender_key)
        else $error("error result carries nonzero fields");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_TOOLONG)
        else $error("status code out of range");

    a_kem_needs_e2e: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK && (has_kem || e2e_rev != 16'd0) |-> has_e2e)
        else $error("kem or e2e version without e2e parameters");

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |->
            {1'b0, payload_offset} + {1'b0, payload_length} <= 16'(MAX_MSG_BYTES))
        else $error("payload span exceeds message limit");

endmodule

bind confirmation_envelope_deframer cedf_checker u_cedf_checker (.*);

FILE: tb/cedf_tb_pkg.sv
// Scoreboard for the confirmation envelope deframer testbench: predicts the
// result item of every message from its bytes and checks the block's results.
// Depends on cedf_pkg.
package cedf_tb_pkg;
    import cedf_pkg::*;

    class envelope_scoreboard;
        // parse state of the message in flight
        bit [14:0] byte_count;
        phase_t    phase;
        bit [16:0] skip_limit;
        bit [7:0]  len_msb;
        bit [15:0] agent_ver;
        bit [15:0] e2e_ver;
        bit [2:0]  err;
        bit [14:0] payload_start;
        bit [15:0] window;
        bit [14:0] mark_pos;
        bit        mark_seen;
        bit [2:0]  flags;           // bit0 e2e, bit1 kem, bit2 sender key

        result_t   expected_envelopes[$];
        int        mismatches;
        int        unexpected;
        int        results_checked;

        function new();
            clear_message();
            mismatches      = 0;
            unexpected      = 0;
            results_checked = 0;
        endfunction

        function void clear_message();
            byte_count    = '0;
            phase         = PH_TAG;
            skip_limit    = '0;
            len_msb       = '0;
            agent_ver     = '0;
            e2e_ver       = '0;
            err           = ST_OK;
            payload_start = '0;
            window        = '0;
            mark_pos      = '0;
            mark_seen     = 1'b0;
            flags         = '0;
        endfunction

        function void note_byte(bit [7:0] b, bit is_last);
            int      pos;
            int      key_len;
            int      total;
            int      pay_off;
            result_t want;
            pos = int'(byte_count);
            if (err == ST_TOOLONG || pos >= MAX_MSG_BYTES) begin
                err   = ST_TOOLONG;
                phase = PH_IDLE;
            end
            else begin
                case (phase)
                    PH_TAG:
                        if (b == CH_KEY) begin
                            flags[2] = 1'b1;
                            phase    = PH_KLEN0;
                        end
                        else if (b == CH_NOKEY)
                            phase = PH_VER0;
                        else begin
                            err   = ST_BADTAG;
                            phase = PH_IDLE;
                        end
                    PH_KLEN0:
                        if (b < LEN_LONG_LT) begin
                            len_msb = b;
                            phase   = PH_KLEN1;
                        end
                        else begin
                            skip_limit = 17'(pos + 1 + b);
                            phase      = PH_KSKIP;
                        end
                    PH_KLEN1:
                    begin
                        key_len    = int'({len_msb, b});
                        skip_limit = 17'(pos + 1 + key_len);
                        if (key_len == 0)
                            phase = PH_VER0;
                        else
                            phase = PH_KSKIP;
                    end
                    PH_KSKIP:
                        if (pos + 1 >= skip_limit)
                            phase = PH_VER0;
                    PH_VER0:
                    begin
                        agent_ver = {b, 8'h00};
                        phase     = PH_VER1;
                    end
                    PH_VER1:
                    begin
                        agent_ver[7:0] = b;
                        phase          = PH_MTAG;
                    end
                    PH_MTAG:
                        if (b == CH_CONF)
                            phase = PH_MAYBE;
                        else begin
                            err   = ST_NOTCONF;
                            phase = PH_IDLE;
                        end
                    PH_MAYBE:
                        if (b == CH_ONE) begin
                            flags[0] = 1'b1;
                            phase    = PH_E2E0;
                        end
                        else if (b == CH_COMMA) begin
                            payload_start = 15'(pos + 1);
                            phase         = PH_TAIL;
                        end
                        else begin
                            err   = ST_BADMAYBE;
                            phase = PH_IDLE;
                        end
                    PH_E2E0:
                    begin
                        e2e_ver = {b, 8'h00};
                        phase   = PH_E2E1;
                    end
                    PH_E2E1:
                    begin
                        e2e_ver[7:0]  = b;
                        skip_limit    = 17'(pos + 1 + 2 * KEY_FIELD_BYTES);
                        payload_start = 15'(skip_limit);
                        phase         = PH_KEYS;
                    end
                    PH_KEYS:
                        if (pos + 1 >= skip_limit)
                            phase = PH_KEM;
                    PH_KEM:
                    begin
                        payload_start = 15'(pos + 1);
                        if (b == CH_ONE) begin
                            flags[1] = 1'b1;
                            window   = '0;
                            phase    = PH_SEARCH;
                        end
                        else
                            phase = PH_TAIL;
                    end
                    PH_SEARCH:
                    begin
                        // only the first marker counts
                        if (!mark_seen && b == MARK_B2 && window == MARK_HEAD) begin
                            mark_seen = 1'b1;
                            mark_pos  = 15'(pos - 2);
                        end
                        window = {window[7:0], b};
                    end
                    default: ;
                endcase
                byte_count = 15'(pos + 1);
            end
            if (!is_last)
                return;

            total       = int'(byte_count);
            pay_off     = 0;
            want        = '0;
            want.status = err;
            if (err == ST_OK) begin
                case (phase)
                    PH_KEM, PH_TAIL:
                        pay_off = int'(payload_start);
                    PH_SEARCH:
                        if (mark_seen && int'(mark_pos) + 5 <= total)
                            pay_off = int'(mark_pos);
                        else
                            pay_off = int'(payload_start);
                    default:
                        want.status = ST_TRUNC;
                endcase
            end
            if (want.status == ST_OK) begin
                want.payload_offset = 15'(pay_off);
                want.payload_length = 15'(total - pay_off);
                want.agent_rev      = agent_ver;
                want.e2e_rev        = e2e_ver;
                want.has_e2e        = flags[0];
                want.has_kem        = flags[1];
                want.had_sender_key = flags[2];
            end
            expected_envelopes.push_back(want);
            clear_message();
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      bad;
            results_checked++;
            if (expected_envelopes.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("result %0d arrived with nothing expected, status %0d",
                             results_checked, got.status);
                return;
            end
            want = expected_envelopes.pop_front();
            bad  = got.status !== want.status
                || got.payload_offset !== want.payload_offset
                || got.payload_length !== want.payload_length
                || got.agent_rev !== want.agent_rev
                || got.e2e_rev !== want.e2e_rev
                || got.has_e2e !== want.has_e2e
                || got.has_kem !== want.has_kem
                || got.had_sender_key !== want.had_sender_key;
            if (bad) begin
                mismatches++;
                if (mismatches + unexpected <= 10) begin
                    $display("result %0d mismatch", results_checked);
                    $display("  expected status %0d off %0d len %0d ver %h e2e %h e2e/kem/key %b%b%b",
                             want.status, want.payload_offset, want.payload_length,
                             want.agent_rev, want.e2e_rev,
                             want.has_e2e, want.has_kem, want.had_sender_key);
                    $display("  actual   status %0d off %0d len %0d ver %h e2e %h e2e/kem/key %b%b%b",
                             got.status, got.payload_offset, got.payload_length,
                             got.agent_rev, got.e2e_rev,
                             got.has_e2e, got.has_kem, got.had_sender_key);
                end
            end
        endfunction

        function int pending();
            return expected_envelopes.size();
        endfunction

        function int failures();
            return mismatches + unexpected + expected_envelopes.size();
        endfunction
    endclass

endpackage

FILE: tb/tb_confirmation_envelope_deframer.sv
// Top-level testbench for confirmation_envelope_deframer: builds directed and
// random messages, drives them byte by byte with random pacing and checks
// every result item. Depends on cedf_pkg, cedf_tb_pkg and the design files.
module tb_confirmation_envelope_deframer;
    import cedf_pkg::*;
    import cedf_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

    // recipe for one message
    typedef struct {
        bit [7:0]  tag;
        bit        two_byte_len;
        int        key_len;
        bit [15:0] agent_ver;
        bit [7:0]  conf_tag;
        bit [7:0]  maybe_byte;
        bit [15:0] e2e_ver;
        bit        kem_present;
        bit [7:0]  kem_byte;
        int        tail_len;
        int        mark_at;     // marker position in the tail, -1 for none
        bit        clean_tail;  // tail bytes that can never form a marker
        int        cut;         // keep only this many bytes, 0 keeps all
    } frame_plan_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  msg_byte;
    logic        last;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [14:0] payload_offset;
    logic [14:0] payload_length;
    logic [15:0] agent_rev;
    logic [15:0] e2e_rev;
    logic        has_e2e;
    logic        has_kem;
    logic        had_sender_key;
    result_t     observed;

    envelope_scoreboard sb = new();

    logic [7:0] frame[$];
    int         burst_left  = 0;
    int         bytes_sent  = 0;
    int         frames_sent = 0;
    int         idle_cycles = 0;
    rx_mode_t   rx_mode     = RX_OPEN;
    int         rx_span     = 0;
    int         rx_tick     = 0;

    confirmation_envelope_deframer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .msg_byte       (msg_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .agent_rev      (agent_rev),
        .e2e_rev        (e2e_rev),
        .has_e2e        (has_e2e),
        .has_kem        (has_kem),
        .had_sender_key (had_sender_key)
    );

    assign observed = {status, payload_offset, payload_length, agent_rev,
                       e2e_rev, has_e2e, has_kem, had_sender_key};

    always #10 clk = ~clk;

    // receiver: switch between open, random and sparse stall patterns
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            if (rx_span == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 2));
                rx_span <= $urandom_range(50, 400);
            end
            else
                rx_span <= rx_span - 1;
            rx_tick <= (rx_tick >= 5) ? 0 : rx_tick + 1;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                default:   out_ready <= (rx_tick == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(observed);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // bytes biased toward the payload marker
    function automatic logic [7:0] marker_biased_byte();
        case ($urandom_range(0, 5))
            0:       return MARK_B0;
            1:       return 8'h00;
            2:       return MARK_B2;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic frame_plan_t base_plan();
        frame_plan_t p;
        p.tag          = CH_NOKEY;
        p.two_byte_len = 1'b0;
        p.key_len      = 0;
        p.agent_ver    = 16'($urandom);
        p.conf_tag     = CH_CONF;
        p.maybe_byte   = CH_COMMA;
        p.e2e_ver      = 16'($urandom);
        p.kem_present  = 1'b0;
        p.kem_byte     = CH_ONE;
        p.tail_len     = 0;
        p.mark_at      = -1;
        p.clean_tail   = 1'b0;
        p.cut          = 0;
        return p;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 400);
            else
                burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        msg_byte <= b;
        last     <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, is_last);
        bytes_sent++;
    endtask

    task automatic send_plan(input frame_plan_t p);
        int tail_start;
        frame.delete();
        frame.push_back(p.tag);
        if (p.tag == CH_KEY) begin
            if (p.two_byte_len)
                frame.push_back(8'(p.key_len >> 8));
            frame.push_back(8'(p.key_len));
            repeat (p.key_len) frame.push_back(8'($urandom));
        end
        frame.push_back(p.agent_ver[15:8]);
        frame.push_back(p.agent_ver[7:0]);
        frame.push_back(p.conf_tag);
        frame.push_back(p.maybe_byte);
        if (p.maybe_byte == CH_ONE) begin
            frame.push_back(p.e2e_ver[15:8]);
            frame.push_back(p.e2e_ver[7:0]);
            // markers inside the keys must be ignored
            repeat (2 * KEY_FIELD_BYTES) frame.push_back(marker_biased_byte());
            if (p.kem_present)
                frame.push_back(p.kem_byte);
        end
        tail_start = frame.size();
        repeat (p.tail_len)
            frame.push_back(p.clean_tail ? (8'h80 | 8'($urandom)) : marker_biased_byte());
        if (p.mark_at >= 0) begin
            if (tail_start + p.mark_at < frame.size())
                frame[tail_start + p.mark_at] = MARK_B0;
            if (tail_start + p.mark_at + 1 < frame.size())
                frame[tail_start + p.mark_at + 1] = 8'h00;
            if (tail_start + p.mark_at + 2 < frame.size())
                frame[tail_start + p.mark_at + 2] = MARK_B2;
        end
        if (p.cut > 0)
            while (frame.size() > p.cut)
                void'(frame.pop_back());
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        frame_plan_t p;
        int          pick;
        int          cut_points[5];
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        msg_byte <= 8'h00;
        last     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty payload right after the comma
        p = base_plan();
        p.agent_ver = 16'hFFFF;
        send_plan(p);
        wait_drained();

        p = base_plan();
        p.tag       = CH_KEY;
        p.key_len   = 32;
        p.agent_ver = 16'h0000;
        p.tail_len  = 3;
        send_plan(p);

        // longest one-byte key length, message ends right after the keys
        p = base_plan();
        p.tag        = CH_KEY;
        p.key_len    = 255;
        p.maybe_byte = CH_ONE;
        p.e2e_ver    = 16'hFFFF;
        send_plan(p);

        // zero two-byte key length, marker at the very start of the tail
        p = base_plan();
        p.tag          = CH_KEY;
        p.two_byte_len = 1'b1;
        p.key_len      = 0;
        p.maybe_byte   = CH_ONE;
        p.e2e_ver      = 16'h0000;
        p.kem_present  = 1'b1;
        p.tail_len     = 10;
        p.mark_at      = 0;
        p.clean_tail   = 1'b1;
        send_plan(p);

        p = base_plan();
        p.tag          = CH_KEY;
        p.two_byte_len = 1'b1;
        p.key_len      = 31;
        p.tail_len     = 1;
        send_plan(p);

        // longest two-byte key length, cut inside the key
        p = base_plan();
        p.tag          = CH_KEY;
        p.two_byte_len = 1'b1;
        p.key_len      = 'h1FFF;
        p.tail_len     = 2;
        p.cut          = 60;
        send_plan(p);

        // KEM marker other than '1'
        p = base_plan();
        p.maybe_byte  = CH_ONE;
        p.kem_present = 1'b1;
        p.kem_byte    = 8'h30;
        p.tail_len    = 5;
        send_plan(p);

        // ends on the KEM marker
        p = base_plan();
        p.maybe_byte  = CH_ONE;
        p.kem_present = 1'b1;
        send_plan(p);

        // marker exactly five bytes before the end, then four (no match)
        p = base_plan();
        p.maybe_byte  = CH_ONE;
        p.kem_present = 1'b1;
        p.tail_len    = 8;
        p.mark_at     = 3;
        p.clean_tail  = 1'b1;
        send_plan(p);
        p.mark_at = 4;
        send_plan(p);

        // error statuses
        p = base_plan();
        p.tag = 8'h00;
        p.cut = 1;
        send_plan(p);
        p = base_plan();
        p.tag        = 8'hFF;
        p.maybe_byte = CH_ONE;
        p.tail_len   = 6;
        send_plan(p);
        p = base_plan();
        p.conf_tag = 8'h63;
        p.tail_len = 4;
        send_plan(p);
        p = base_plan();
        p.maybe_byte = 8'hCE;
        p.tail_len   = 4;
        send_plan(p);

        // truncation after tag, after version, after 'C', inside e2e, inside keys
        cut_points = '{1, 3, 4, 6, 142};
        foreach (cut_points[i]) begin
            p = base_plan();
            p.maybe_byte  = CH_ONE;
            p.kem_present = 1'b1;
            p.cut         = cut_points[i];
            send_plan(p);
        end
        // truncation inside the key length and inside the key
        p = base_plan();
        p.tag          = CH_KEY;
        p.two_byte_len = 1'b1;
        p.key_len      = 300;
        p.cut          = 2;
        send_plan(p);
        p.cut = 100;
        send_plan(p);

        // random messages, mostly well formed
        while (bytes_sent < 1950 || frames_sent < 26) begin
            p = base_plan();
            if ($urandom_range(0, 9) < 4) begin
                p.tag          = CH_KEY;
                p.two_byte_len = 1'($urandom_range(0, 1));
                if (p.two_byte_len)
                    p.key_len = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 700)
                                                             : $urandom_range(0, 255);
                else
                    p.key_len = ($urandom_range(0, 7) == 0) ? $urandom_range(81, 255)
                                                            : $urandom_range(32, 80);
            end
            if ($urandom_range(0, 99) < 35) begin
                p.maybe_byte  = CH_ONE;
                p.kem_present = ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 9) >= 7)
                    p.kem_byte = 8'($urandom);
            end
            p.tail_len   = $urandom_range(0, 24);
            p.clean_tail = 1'($urandom_range(0, 1));
            if (p.tail_len > 0 && $urandom_range(0, 9) < 6)
                p.mark_at = $urandom_range(0, p.tail_len - 1);
            // a quarter of the messages are broken in one place
            pick = $urandom_range(0, 99);
            if (pick < 6)
                p.tag = 8'($urandom);
            else if (pick < 11)
                p.conf_tag = 8'($urandom);
            else if (pick < 16)
                p.maybe_byte = 8'($urandom);
            else if (pick < 25)
                p.cut = $urandom_range(1, 150);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
            send_plan(p);
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (8) @(posedge clk);
        if (sb.failures() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: confirmation_envelope_deframer.f
design/cedf_pkg.sv
design/cedf_parser.sv
design/cedf_out_reg.sv
design/confirmation_envelope_deframer.sv
design/cedf_checker.sv
tb/cedf_tb_pkg.sv
tb/tb_confirmation_envelope_deframer.sv
